>>> design/sobm_pkg.sv
package sobm_pkg;

	// configuration register indexes
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_CFG_W  = 11;
	localparam int HEIGHT_CFG_W = 13;
	localparam int ROW_W        = 12;

	localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_CAP   = 13'd4096;
	localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_MIN   = 13'd3;

	localparam int PIX_W    = 8;
	localparam int GRAD_W   = 10;
	localparam int SUM_W    = 21;
	localparam int MAG_W    = 8;
	localparam int OCOL_W   = 10;
	localparam int OROW_W   = 12;
	localparam int TDATA_W  = 32;

	localparam logic [SUM_W-1:0] ROOT_BIT_START = 21'h100000;
	localparam logic [MAG_W-1:0] MAG_MAX        = 8'd255;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_SQUARE,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic clear_wr;
		logic step;
		logic calc;
		logic square;
		logic root_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic emit;
		logic root_last;
		logic out_free;
	} sts_t;

endpackage

>>> design/sobm_datapath.sv
module sobm_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sobm_pkg::cmd_t                      cmd,
	output sobm_pkg::sts_t                      sts,
	input  logic [sobm_pkg::PIX_W-1:0]          pixel,
	input  logic                                cfg_we,
	input  logic [sobm_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [sobm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sobm_pkg::MAG_W-1:0]          edge_magnitude,
	output logic [sobm_pkg::OCOL_W-1:0]         out_col,
	output logic [sobm_pkg::OROW_W-1:0]         out_row,
	output logic                                frame_last
);
	import sobm_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EW  = $clog2(MAX_WIDTH + 1);
	localparam int CFW = (EW > WIDTH_CFG_W) ? EW : WIDTH_CFG_W;

	logic [WIDTH_CFG_W-1:0]  image_width_q;
	logic [HEIGHT_CFG_W-1:0] image_height_q;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    clr_q;

	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_older_q, rd_newer_q, pix_q;
	logic [PIX_W-1:0] win_q [9];

	logic [GRAD_W-1:0] ax_q, ay_q;
	logic [SUM_W-1:0]  rem_q, root_q, bit_q;
	logic [OCOL_W-1:0] col_res_q;
	logic [OROW_W-1:0] row_res_q;
	logic              last_res_q;

	logic              out_valid_q;
	logic [MAG_W-1:0]  mag_q;
	logic [OCOL_W-1:0] ocol_q;
	logic [OROW_W-1:0] orow_q;
	logic              olast_q;

	logic [CFW-1:0]          width_ext;
	logic [EW-1:0]           eff_w;
	logic [HEIGHT_CFG_W-1:0] eff_h;
	logic [CW:0]             col_ext, col_inc, w_ext;
	logic [ROW_W:0]          row_ext, row_inc;
	logic                    emit;
	logic [GRAD_W-1:0]       gx_pos, gx_neg, gy_pos, gy_neg;
	logic [SUM_W:0]          trial;
	logic [SUM_W-3:0]        root_div4;
	logic [MAG_W-1:0]        mag_sat;

	// effective frame size, clamped to the supported range
	always_comb begin
		width_ext = CFW'(image_width_q);
		if (width_ext < CFW'(3))
			eff_w = EW'(3);
		else if (width_ext > CFW'(MAX_WIDTH))
			eff_w = EW'(MAX_WIDTH);
		else
			eff_w = EW'(width_ext);
		if (image_height_q < HEIGHT_MIN)
			eff_h = HEIGHT_MIN;
		else if (image_height_q > HEIGHT_CAP)
			eff_h = HEIGHT_CAP;
		else
			eff_h = image_height_q;
	end

	assign col_ext = {1'b0, col_q};
	assign col_inc = col_ext + (CW+1)'(1);
	assign w_ext   = (CW+1)'(eff_w);
	assign row_ext = {1'b0, row_q};
	assign row_inc = row_ext + (ROW_W+1)'(1);

	assign emit = (col_q >= CW'(2)) && (row_q >= ROW_W'(2))
		&& (col_ext < w_ext) && (row_ext < eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[WIDTH_CFG_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clear_wr)
				clr_q <= clr_q + CW'(1);
			if (cmd.step) begin
				if (col_inc >= w_ext) begin
					col_q <= '0;
					row_q <= (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
		end
	end

	// line stores: read on accept, write back on the following cycle
	always_ff @(posedge clk) begin
		if (cmd.clear_wr)
			older_mem[clr_q] <= '0;
		else if (cmd.step)
			older_mem[col_q] <= rd_newer_q;
		if (cmd.load)
			rd_older_q <= older_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_wr)
			newer_mem[clr_q] <= '0;
		else if (cmd.step)
			newer_mem[col_q] <= pix_q;
		if (cmd.load)
			rd_newer_q <= newer_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			pix_q <= pixel;
		if (cmd.step) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2]   <= rd_older_q;
			win_q[5]   <= rd_newer_q;
			win_q[8]   <= pix_q;
			col_res_q  <= OCOL_W'(col_q - CW'(1));
			row_res_q  <= row_q - ROW_W'(1);
			last_res_q <= (col_inc == w_ext) && (row_inc == eff_h);
		end
	end

	// gradients as differences of the two non-negative kernel halves
	assign gx_pos = GRAD_W'(win_q[2]) + GRAD_W'({win_q[5], 1'b0}) + GRAD_W'(win_q[8]);
	assign gx_neg = GRAD_W'(win_q[0]) + GRAD_W'({win_q[3], 1'b0}) + GRAD_W'(win_q[6]);
	assign gy_pos = GRAD_W'(win_q[6]) + GRAD_W'({win_q[7], 1'b0}) + GRAD_W'(win_q[8]);
	assign gy_neg = GRAD_W'(win_q[0]) + GRAD_W'({win_q[1], 1'b0}) + GRAD_W'(win_q[2]);

	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			ax_q <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
			ay_q <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
		end
		if (cmd.square) begin
			rem_q  <= SUM_W'(ax_q) * SUM_W'(ax_q) + SUM_W'(ay_q) * SUM_W'(ay_q);
			root_q <= '0;
			bit_q  <= ROOT_BIT_START;
		end else if (cmd.root_step) begin
			// one result bit of the integer square root per cycle
			if ({1'b0, rem_q} >= trial) begin
				rem_q  <= rem_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root_div4 = root_q[SUM_W-1:2];
	assign mag_sat   = (root_div4 > (SUM_W-2)'(MAG_MAX)) ? MAG_MAX : root_div4[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mag_q   <= mag_sat;
			ocol_q  <= col_res_q;
			orow_q  <= row_res_q;
			olast_q <= last_res_q;
		end
	end

	assign sts.clear_done = (clr_q == CW'(MAX_WIDTH - 1));
	assign sts.emit       = emit;
	assign sts.root_last  = bit_q[0];
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign edge_magnitude = mag_q;
	assign out_col        = ocol_q;
	assign out_row        = orow_q;
	assign frame_last     = olast_q;

	a_root_runs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_step |-> bit_q != '0)
		else $error("root iteration past its last bit");

	a_result_complete: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> bit_q == '0)
		else $error("result loaded before the root finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_clear_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !cmd.step && !cmd.load)
		else $error("line store used during clearing pass");

endmodule

>>> design/sobm_ctrl.sv
module sobm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output sobm_pkg::cmd_t cmd,
	input  sobm_pkg::sts_t sts
);
	import sobm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_READ;
			ST_READ:   state_d = sts.emit ? ST_CALC : ST_IDLE;
			ST_CALC:   state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_ROOT;
			ST_ROOT:   if (sts.root_last) state_d = ST_DONE;
			ST_DONE:   if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR:  cmd.clear_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ:   cmd.step = 1'b1;
			ST_CALC:   cmd.calc = 1'b1;
			ST_SQUARE: cmd.square = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_DONE:   cmd.out_load = sts.out_free;
			default:   ;
		endcase
	end

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_READ)
		else $error("accepted pixel not followed by line store update");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output busy");

	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_CLEAR && state_q != ST_CLEAR |-> $past(sts.clear_done))
		else $error("clearing pass left early");

endmodule

>>> design/sobel_edge_magnitude.sv
// 3x3 Sobel gradient magnitude over an 8-bit grayscale frame in raster order. Each
// accepted pixel updates two line stores and the 3x3 window; for interior positions the
// block returns floor(isqrt(gx^2 + gy^2) / 4), clamped to 255, with the centre's column,
// row and a frame_last flag on the final interior result. One pixel is in work at a time:
// a pixel with no result ends after its line store update, one with a result runs the
// 11-step shared square root unit (one root bit per cycle). Finished results sit in an
// output register, so the next pixel is taken while a result waits. After reset the line
// stores are cleared one column per cycle, all MAX_WIDTH columns, before the first pixel
// is accepted; configuration writes are taken at any time.
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] pixel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sobm_pkg::TDATA_W-1:0]      m_tdata,   // [7:0] edge_magnitude,
	                                                     // [17:8] out_col, [29:18] out_row
	output logic                              m_tlast,   // frame_last
	input  logic                              cfg_we,
	input  logic [sobm_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [sobm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import sobm_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [MAG_W-1:0]  edge_magnitude;
	logic [OCOL_W-1:0] out_col;
	logic [OROW_W-1:0] out_row;

	sobm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sobm_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.pixel          (s_tdata),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.edge_magnitude (edge_magnitude),
		.out_col        (out_col),
		.out_row        (out_row),
		.frame_last     (m_tlast)
	);

	assign m_tdata = {
		(TDATA_W - MAG_W - OCOL_W - OROW_W)'(0),
		out_row,
		out_col,
		edge_magnitude
	};

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import sobm_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PIXELS = 480;

	typedef struct {
		logic [MAG_W-1:0]  mag;
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
		logic              last;
	} edge_result_t;

	class edge_scoreboard;
		logic [WIDTH_CFG_W-1:0]  width_reg;
		logic [HEIGHT_CFG_W-1:0] height_reg;
		logic [PIX_W-1:0]        older_line [LINE_DEPTH];
		logic [PIX_W-1:0]        newer_line [LINE_DEPTH];
		int                      win [9];
		int unsigned             col_pos;
		int unsigned             row_pos;
		edge_result_t            due_edges [$];
		int                      errors;
		int                      checked;
		int                      pixels;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (older_line[i]) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			foreach (win[i]) win[i] = 0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			checked = 0;
			pixels = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_IMAGE_WIDTH)
				width_reg = val[WIDTH_CFG_W-1:0];
			else
				height_reg = val[HEIGHT_CFG_W-1:0];
		endfunction

		function int unsigned eff_width();
			if (width_reg < 3) return 3;
			if (width_reg > LINE_DEPTH) return LINE_DEPTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg < HEIGHT_MIN) return HEIGHT_MIN;
			if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
			return height_reg;
		endfunction

		// floor of the square root, one result bit at a time from the top
		function int unsigned root_floor(int unsigned n);
			int unsigned r;
			int unsigned t;
			r = 0;
			for (int b = 11; b >= 0; b--) begin
				t = r | (32'd1 << b);
				if (t * t <= n) r = t;
			end
			return r;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] pix);
			int unsigned  w;
			int unsigned  h;
			int unsigned  c;
			int unsigned  r;
			int unsigned  idx;
			int unsigned  ax;
			int unsigned  ay;
			int unsigned  m;
			int           gx;
			int           gy;
			logic [PIX_W-1:0] top;
			logic [PIX_W-1:0] mid;
			edge_result_t res;
			w = eff_width();
			h = eff_height();
			c = col_pos;
			r = row_pos;
			pixels++;
			idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
			top = older_line[idx];
			mid = newer_line[idx];
			older_line[idx] = mid;
			newer_line[idx] = pix;
			for (int k = 0; k < 3; k++) begin
				win[k*3]   = win[k*3+1];
				win[k*3+1] = win[k*3+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = pix;
			if (c >= 2 && r >= 2 && c < w && r < h) begin
				gx = (win[2] + 2*win[5] + win[8]) - (win[0] + 2*win[3] + win[6]);
				gy = (win[6] + 2*win[7] + win[8]) - (win[0] + 2*win[1] + win[2]);
				ax = (gx < 0) ? -gx : gx;
				ay = (gy < 0) ? -gy : gy;
				m = root_floor(ax*ax + ay*ay) >> 2;
				if (m > MAG_MAX) m = MAG_MAX;
				res.mag  = m[MAG_W-1:0];
				res.col  = OCOL_W'(c - 1);
				res.row  = OROW_W'(r - 1);
				res.last = (c == w - 1) && (r == h - 1);
				due_edges.push_back(res);
			end
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_result(logic [TDATA_W-1:0] data, logic last);
			edge_result_t want;
			if (due_edges.size() == 0) begin
				$error("edge result with none due: tdata %h tlast %b", data, last);
				errors++;
				return;
			end
			want = due_edges.pop_front();
			checked++;
			if (data[7:0] !== want.mag) begin
				$error("edge_magnitude: expected %0d, got %0d", want.mag, data[7:0]);
				errors++;
			end
			if (data[17:8] !== want.col) begin
				$error("out_col: expected %0d, got %0d", want.col, data[17:8]);
				errors++;
			end
			if (data[29:18] !== want.row) begin
				$error("out_row: expected %0d, got %0d", want.row, data[29:18]);
				errors++;
			end
			if (last !== want.last) begin
				$error("frame_last: expected %b, got %b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [7:0]              s_tdata;   // [7:0] pixel
	logic                    m_tvalid;
	logic                    m_tready;
	logic [TDATA_W-1:0]      m_tdata;   // [7:0] edge_magnitude, [17:8] out_col, [29:18] out_row
	logic                    m_tlast;   // frame_last
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_addr;
	logic [CFG_DATA_W-1:0]   cfg_wdata;

	edge_scoreboard sb = new();
	int src_gap_max = 16;
	int snk_gap_max = 16;

	sobel_edge_magnitude uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 4;
			default: return 16;
		endcase
	endfunction

	// extremes show up often so saturated gradients are common
	function automatic logic [7:0] rand_pixel();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_pixel(input logic [7:0] pix);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(pix);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.due_edges.size() != 0) @(posedge clk);
		// a pixel with no result may still be in work
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val[CFG_DATA_W-1:0]);
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, snk_gap_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tlast);
			@(negedge clk);
		end
	end

	initial begin
		int random_sent;
		int frame_px;
		int phase_len;
		int unsigned val;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_IMAGE_WIDTH;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest frame: saturating, mirrored (negative gradients), then uniform
		write_reg(CFG_IMAGE_WIDTH, 3);
		write_reg(CFG_IMAGE_HEIGHT, 3);
		for (int k = 0; k < 9; k++)
			send_pixel((k % 3 == 2 || k == 7) ? 8'hFF : 8'h00);
		for (int k = 0; k < 9; k++)
			send_pixel((k % 3 == 0 || k == 1) ? 8'hFF : 8'h00);
		repeat (9) send_pixel(8'hFF);
		drain();

		// reach row 2 on a narrow frame, then widen to the full line mid-frame
		src_gap_max = pick_gap();
		snk_gap_max = pick_gap();
		repeat (6) send_pixel(rand_pixel());
		drain();
		write_reg(CFG_IMAGE_WIDTH, LINE_DEPTH);
		repeat (LINE_DEPTH) send_pixel(rand_pixel());
		drain();

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			src_gap_max = pick_gap();
			snk_gap_max = pick_gap();
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0:       val = $urandom_range(0, 2);
					1:       val = $urandom_range(LINE_DEPTH + 1, 2047);
					2:       val = $urandom_range(13, LINE_DEPTH);
					default: val = $urandom_range(3, 12);
				endcase
				// bits above the register width are ignored
				val = val | ($urandom_range(0, 3) << WIDTH_CFG_W);
				write_reg(CFG_IMAGE_WIDTH, val);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0:       val = $urandom_range(0, 2);
					1:       val = $urandom_range(HEIGHT_CAP + 1, 8191);
					2:       val = $urandom_range(9, HEIGHT_CAP);
					default: val = $urandom_range(3, 8);
				endcase
				write_reg(CFG_IMAGE_HEIGHT, val);
			end
			frame_px = sb.eff_width() * sb.eff_height();
			phase_len = (frame_px <= 60) ? frame_px * $urandom_range(1, 3)
			                             : $urandom_range(1, 80);
			repeat (phase_len) send_pixel(rand_pixel());
			random_sent += phase_len;
			drain();
		end

		$display("%0d pixels sent, %0d edge results checked, %0d mismatches",
		         sb.pixels, sb.checked, sb.errors);
		$display("sizes from 3x3 up to a full 1024 line, clamped sizes and a mid-frame widening");
		if (sb.errors == 0 && sb.due_edges.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d edge results still due", sb.due_edges.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
